>>> hdl/sfr_pkg.sv
package sfr_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPL_MAX_DEF    = 8;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 4;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 4;
    localparam int IDX_W           = 3;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LEN   = 4'd0,
        CFG_PATTERN_BYTES = 4'd1,
        CFG_REPL_LEN      = 4'd2,
        CFG_REPL_BYTES    = 4'd3
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic              out_last;
    } out_word_t;

    // one queued burst: up to eight bytes sent in order, low byte first
    typedef struct packed {
        logic [CFG_DATA_W-1:0] data;
        logic [LEN_W-1:0]      count;
        logic                  last;
    } cmd_t;

endpackage

>>> hdl/sfr_front.sv
module sfr_front #(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sfr_pkg::in_word_t                 s_data,
    input  logic [sfr_pkg::LEN_W-1:0]         plen,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]    pattern_bytes,
    input  logic [sfr_pkg::LEN_W-1:0]         rlen,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]    repl_bytes,
    input  logic                              clear_win,
    input  logic                              q_ready,
    output logic                              q_push,
    output sfr_pkg::cmd_t                     q_cmd,
    output logic [$clog2(PATTERN_MAX+1)-1:0]  win_count
);

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);

    logic [sfr_pkg::BYTE_W-1:0] win_reg  [PATTERN_MAX];
    logic [sfr_pkg::BYTE_W-1:0] win_next [PATTERN_MAX];
    logic [sfr_pkg::BYTE_W-1:0] ext      [PATTERN_MAX];
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [sfr_pkg::LEN_W-1:0]  n;
    logic [sfr_pkg::LEN_W-1:0]  n_inc;
    logic                       full;
    logic                       match;
    logic                       accept;
    logic [sfr_pkg::CFG_DATA_W-1:0] ext_packed;

    assign s_ready   = q_ready;
    assign accept    = s_valid && s_ready;
    assign win_count = count_reg;

    always_comb begin
        if (sfr_pkg::LEN_W'(count_reg) >= plen) begin
            n = plen - sfr_pkg::LEN_W'(1);
        end else begin
            n = sfr_pkg::LEN_W'(count_reg);
        end
        n_inc = n + sfr_pkg::LEN_W'(1);
        full  = (n_inc == plen);
    end

    // window plus the new byte, oldest first
    always_comb begin
        ext_packed = '0;
        match      = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (sfr_pkg::LEN_W'(i) < n) begin
                ext[i] = win_reg[i];
            end else begin
                ext[i] = s_data.in_byte;
            end
            ext_packed[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] = ext[i];
            if (sfr_pkg::LEN_W'(i) < plen &&
                ext[i] != pattern_bytes[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        q_cmd.last = s_data.in_last;
        if (full && match) begin
            q_cmd.data  = repl_bytes;
            q_cmd.count = rlen;
        end else begin
            q_cmd.data = ext_packed;
            if (s_data.in_last) begin
                q_cmd.count = n_inc;
            end else if (full) begin
                q_cmd.count = sfr_pkg::LEN_W'(1);
            end else begin
                q_cmd.count = '0;
            end
        end
        q_push = accept && (q_cmd.count != '0 || s_data.in_last);
    end

    always_comb begin
        count_next = count_reg;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            win_next[i] = win_reg[i];
        end
        if (clear_win) begin
            count_next = '0;
        end else if (accept) begin
            if (s_data.in_last || (full && match)) begin
                count_next = '0;
            end else if (full) begin
                // drop the oldest byte, it went out in the queued burst
                for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                    win_next[i] = ext[i+1];
                end
                count_next = CNT_W'(n);
            end else begin
                for (int i = 0; i < PATTERN_MAX; i++) begin
                    win_next[i] = ext[i];
                end
                count_next = CNT_W'(n_inc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            win_reg[i] <= win_next[i];
        end
    end

endmodule

>>> hdl/sfr_queue.sv
module sfr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sfr_pkg::cmd_t push_cmd,
    output logic          in_ready,
    input  logic          pop,
    output logic          out_valid,
    output sfr_pkg::cmd_t out_cmd
);

    localparam int AW = (sfr_pkg::QUEUE_DEPTH > 1) ? $clog2(sfr_pkg::QUEUE_DEPTH) : 1;

    sfr_pkg::cmd_t mem_reg [sfr_pkg::QUEUE_DEPTH];
    logic [AW:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW:0]   rd_ptr_reg, rd_ptr_next;
    logic          empty;
    logic          full;

    assign empty     = (wr_ptr_reg == rd_ptr_reg);
    assign full      = (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]) &&
                       (wr_ptr_reg[AW] != rd_ptr_reg[AW]);
    assign in_ready  = !full;
    assign out_valid = !empty;
    assign out_cmd   = mem_reg[rd_ptr_reg[AW-1:0]];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push && !full) begin
            wr_ptr_next = wr_ptr_reg + (AW+1)'(1);
        end
        if (pop && !empty) begin
            rd_ptr_next = rd_ptr_reg + (AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= push_cmd;
        end
    end

endmodule

>>> hdl/sfr_back.sv
module sfr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  sfr_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output sfr_pkg::out_word_t m_data
);

    sfr_pkg::cmd_t               cmd_reg, cmd_next;
    logic                        busy_reg, busy_next;
    logic [sfr_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                        m_valid_reg, m_valid_next;
    sfr_pkg::out_word_t          m_word_reg, m_word_next;
    logic                        out_free;
    logic                        emit;
    logic                        at_end;
    logic                        fin;
    logic [sfr_pkg::CFG_DATA_W-1:0] shifted;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = busy_reg && out_free;
    assign at_end   = (cmd_reg.count == '0) ||
                      ({1'b0, idx_reg} == cmd_reg.count - sfr_pkg::LEN_W'(1));
    assign fin      = emit && at_end;
    assign q_pop    = q_valid && (!busy_reg || fin);
    assign shifted  = cmd_reg.data >> {idx_reg, 3'b000};

    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

    always_comb begin
        cmd_next     = cmd_reg;
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        m_word_next  = m_word_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (emit) begin
            m_valid_next = 1'b1;
            // a burst of zero bytes only reaches here as the empty end word
            if (cmd_reg.count == '0) begin
                m_word_next.out_byte = '0;
                m_word_next.has_byte = 1'b0;
            end else begin
                m_word_next.out_byte = shifted[sfr_pkg::BYTE_W-1:0];
                m_word_next.has_byte = 1'b1;
            end
            m_word_next.out_last = cmd_reg.last && at_end;
            idx_next = idx_reg + sfr_pkg::IDX_W'(1);
        end

        if (q_pop) begin
            cmd_next  = q_cmd;
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (fin) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        m_word_reg <= m_word_next;
    end

endmodule

>>> hdl/stream_find_replace.sv
// Streaming find and replace: every leftmost, non-overlapping occurrence of the pattern
// (1 to PATTERN_MAX bytes) in a byte string is replaced by the replacement (0 to REPL_MAX
// bytes); in_last ends a string and flushes held bytes, and a string that leaves nothing to
// send ends with one word that has has_byte 0 and out_last 1. The front takes one byte per
// cycle while the queue has room, holds up to pattern_len-1 bytes and queues a burst of 0 to
// 8 output bytes per input byte into a two-entry queue; the back sends one word per cycle
// while m_ready is high, through its single output port. A result passes through the queue,
// the back's command register and its output register. Write configuration only while the
// block is idle; writing pattern_len drops any held bytes.
module stream_find_replace #(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
    parameter int REPL_MAX    = sfr_pkg::REPL_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sfr_pkg::in_word_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sfr_pkg::out_word_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [sfr_pkg::LEN_W-1:0] PLEN_MAX = sfr_pkg::LEN_W'(PATTERN_MAX);
    localparam logic [sfr_pkg::LEN_W-1:0] RLEN_MAX = sfr_pkg::LEN_W'(REPL_MAX);

    logic [sfr_pkg::LEN_W-1:0]      pattern_len_reg;
    logic [sfr_pkg::CFG_DATA_W-1:0] pattern_bytes_reg;
    logic [sfr_pkg::LEN_W-1:0]      repl_len_reg;
    logic [sfr_pkg::CFG_DATA_W-1:0] repl_bytes_reg;
    logic [sfr_pkg::LEN_W-1:0]      plen;
    logic [sfr_pkg::LEN_W-1:0]      rlen;
    logic                           cfg_wr;
    logic                           clear_win;

    logic                           q_push;
    logic                           q_in_ready;
    sfr_pkg::cmd_t                  q_push_cmd;
    logic                           q_pop;
    logic                           q_out_valid;
    sfr_pkg::cmd_t                  q_out_cmd;
    logic [$clog2(PATTERN_MAX+1)-1:0] win_count;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign clear_win = cfg_wr && (cfg_index == sfr_pkg::CFG_PATTERN_LEN);

    always_comb begin
        if (pattern_len_reg == '0) begin
            plen = sfr_pkg::LEN_W'(1);
        end else if (pattern_len_reg > PLEN_MAX) begin
            plen = PLEN_MAX;
        end else begin
            plen = pattern_len_reg;
        end
        if (repl_len_reg > RLEN_MAX) begin
            rlen = RLEN_MAX;
        end else begin
            rlen = repl_len_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_len_reg   <= sfr_pkg::LEN_W'(1);
            pattern_bytes_reg <= '0;
            repl_len_reg      <= '0;
            repl_bytes_reg    <= '0;
        end else if (cfg_wr) begin
            case (cfg_index)
                sfr_pkg::CFG_PATTERN_LEN: begin
                    pattern_len_reg <= cfg_data[sfr_pkg::LEN_W-1:0];
                end
                sfr_pkg::CFG_PATTERN_BYTES: begin
                    pattern_bytes_reg <= cfg_data;
                end
                sfr_pkg::CFG_REPL_LEN: begin
                    repl_len_reg <= cfg_data[sfr_pkg::LEN_W-1:0];
                end
                sfr_pkg::CFG_REPL_BYTES: begin
                    repl_bytes_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    sfr_front #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .plen         (plen),
        .pattern_bytes(pattern_bytes_reg),
        .rlen         (rlen),
        .repl_bytes   (repl_bytes_reg),
        .clear_win    (clear_win),
        .q_ready      (q_in_ready),
        .q_push       (q_push),
        .q_cmd        (q_push_cmd),
        .win_count    (win_count)
    );

    sfr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .in_ready (q_in_ready),
        .pop      (q_pop),
        .out_valid(q_out_valid),
        .out_cmd  (q_out_cmd)
    );

    sfr_back u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_valid(q_out_valid),
        .q_cmd  (q_out_cmd),
        .q_pop  (q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // an empty word only ever closes a string
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.has_byte) |-> (m_data.out_last && m_data.out_byte == '0))
        else $error("empty word without end mark");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> q_in_ready)
        else $error("burst queue overflow");

    // the end of a string leaves the window empty
    a_flush_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.in_last) |=> (win_count == '0))
        else $error("window not flushed at end of string");

    // held bytes stay below the pattern length unless configuration was just written
    a_window_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (!$past(cfg_wr)) |-> (sfr_pkg::LEN_W'(win_count) < plen))
        else $error("window holds a full pattern");

endmodule
